// ----- hw/rtl/wmfac_pkg.sv -----
// Shared types, constants and CRC/length helpers for the wireless M-Bus format A frame checker.
package wmfac_pkg;

	localparam int HEADER_BLOCK_BYTES = 12;
	localparam int DATA_BLOCK_BYTES   = 18;
	localparam int LEN_MIN            = 9;
	localparam int LEN_MAX            = 55;
	localparam int EXP_LEN_W          = 9;
	localparam int FRAME_LEN_W        = 7;
	localparam int BLK_POS_W          = 5;

	localparam logic [15:0] CRC_POLY = 16'h3D65;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_LONG     = 3'd2,
		ERR_HDR_CRC  = 3'd3,
		ERR_LEN_OVER = 3'd4,
		ERR_LEN_MIN  = 3'd5,
		ERR_LEN_MAX  = 3'd6,
		ERR_BLK_CRC  = 3'd7
	} err_code_t;

	typedef struct packed {
		logic                   ok;
		logic [FRAME_LEN_W-1:0] length;
		err_code_t              err;
	} verdict_t;

	// One byte through the CRC-16, high bit first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Frame length from the L field: L + 3 + 2 * ceil((L - 9) / 16).
	function automatic logic [EXP_LEN_W-1:0] length_from_l(input logic [7:0] l);
		logic [EXP_LEN_W-1:0] sum;
		logic [EXP_LEN_W-1:0] extra;
		sum   = {1'b0, l} + EXP_LEN_W'(6);
		extra = '0;
		if (l > 8'(LEN_MIN)) begin
			extra = sum >> 4;
		end
		return {1'b0, l} + EXP_LEN_W'(3) + {extra[EXP_LEN_W-2:0], 1'b0};
	endfunction

endpackage

// ----- hw/rtl/wmfac_track.sv -----
// Frame tracking state: block CRCs, byte count, expected length and end-of-frame verdict.
module wmfac_track
	import wmfac_pkg::*;
#(
	parameter int MAX_RECEIVED_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output verdict_t   verdict
);

	localparam int CNT_W = $clog2(MAX_RECEIVED_BYTES + 2);

	logic [15:0]          crc_q, crc_nxt;
	logic [CNT_W-1:0]     count_q, count_nxt;
	logic [BLK_POS_W-1:0] pos_q, pos_nxt;
	logic [EXP_LEN_W-1:0] exp_q, exp_nxt;
	logic                 hdr_bad_q, hdr_bad_nxt;
	logic                 blk_bad_q, blk_bad_nxt;
	logic                 hi_match_q, hi_match_nxt;

	logic [15:0]          crc_inv;
	logic [CNT_W-1:0]     blk_start;
	logic [EXP_LEN_W-1:0] blk_rest;
	logic [BLK_POS_W-1:0] blk_len;
	logic [BLK_POS_W:0]   pos_plus2;
	logic                 low_bad;

	assign crc_inv = ~crc_q;
	assign low_bad = !(hi_match_q && (crc_inv[7:0] == data_byte));

	always_comb begin
		crc_nxt      = crc_q;
		pos_nxt      = pos_q;
		exp_nxt      = exp_q;
		hdr_bad_nxt  = hdr_bad_q;
		blk_bad_nxt  = blk_bad_q;
		hi_match_nxt = hi_match_q;
		blk_start    = count_q - CNT_W'(pos_q);
		blk_rest     = '0;
		blk_len      = '0;
		pos_plus2    = {1'b0, pos_q} + (BLK_POS_W+1)'(2);

		if (count_q < CNT_W'(MAX_RECEIVED_BYTES)) begin
			if (count_q == '0) begin
				exp_nxt = length_from_l(data_byte);
			end
			blk_rest = exp_nxt - EXP_LEN_W'(blk_start);
			blk_len  = (blk_rest > EXP_LEN_W'(DATA_BLOCK_BYTES)) ?
				BLK_POS_W'(DATA_BLOCK_BYTES) : blk_rest[BLK_POS_W-1:0];

			if (count_q < CNT_W'(HEADER_BLOCK_BYTES - 2)) begin
				crc_nxt = crc_feed(crc_q, data_byte);
			end else if (count_q == CNT_W'(HEADER_BLOCK_BYTES - 2)) begin
				hi_match_nxt = (crc_inv[15:8] == data_byte);
			end else if (count_q == CNT_W'(HEADER_BLOCK_BYTES - 1)) begin
				hdr_bad_nxt = low_bad;
				crc_nxt     = '0;
				pos_nxt     = '0;
			end else if (EXP_LEN_W'(count_q) < exp_nxt) begin
				if (pos_plus2 < {1'b0, blk_len}) begin
					crc_nxt = crc_feed(crc_q, data_byte);
					pos_nxt = pos_q + BLK_POS_W'(1);
				end else if (pos_plus2 == {1'b0, blk_len}) begin
					hi_match_nxt = (crc_inv[15:8] == data_byte);
					pos_nxt      = pos_q + BLK_POS_W'(1);
				end else begin
					// closing CRC byte of a data block
					if (low_bad) begin
						blk_bad_nxt = 1'b1;
					end
					crc_nxt = '0;
					pos_nxt = '0;
				end
			end
		end

		count_nxt = count_q;
		if (count_q < CNT_W'(MAX_RECEIVED_BYTES + 1)) begin
			count_nxt = count_q + CNT_W'(1);
		end
	end

	// Verdict in check order; first failure wins.
	always_comb begin
		verdict.err = ERR_NONE;
		if (count_nxt < CNT_W'(HEADER_BLOCK_BYTES)) begin
			verdict.err = ERR_SHORT;
		end else if (count_nxt > CNT_W'(MAX_RECEIVED_BYTES)) begin
			verdict.err = ERR_LONG;
		end else if (hdr_bad_nxt) begin
			verdict.err = ERR_HDR_CRC;
		end else if (exp_nxt > EXP_LEN_W'(count_nxt)) begin
			verdict.err = ERR_LEN_OVER;
		end else if (exp_nxt < EXP_LEN_W'(LEN_MIN)) begin
			verdict.err = ERR_LEN_MIN;
		end else if (exp_nxt > EXP_LEN_W'(LEN_MAX)) begin
			verdict.err = ERR_LEN_MAX;
		end else if (blk_bad_nxt) begin
			verdict.err = ERR_BLK_CRC;
		end
		verdict.ok     = (verdict.err == ERR_NONE);
		verdict.length = '0;
		if (verdict.ok) begin
			verdict.length = (exp_nxt < EXP_LEN_W'(HEADER_BLOCK_BYTES)) ?
				FRAME_LEN_W'(HEADER_BLOCK_BYTES) : exp_nxt[FRAME_LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			exp_q      <= '0;
			hdr_bad_q  <= 1'b0;
			blk_bad_q  <= 1'b0;
			hi_match_q <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				crc_q      <= '0;
				count_q    <= '0;
				pos_q      <= '0;
				exp_q      <= '0;
				hdr_bad_q  <= 1'b0;
				blk_bad_q  <= 1'b0;
				hi_match_q <= 1'b0;
			end else begin
				crc_q      <= crc_nxt;
				count_q    <= count_nxt;
				pos_q      <= pos_nxt;
				exp_q      <= exp_nxt;
				hdr_bad_q  <= hdr_bad_nxt;
				blk_bad_q  <= blk_bad_nxt;
				hi_match_q <= hi_match_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && frame_end |=> count_q == '0 && crc_q == '0)
		else $error("tracking state not cleared after frame end");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECEIVED_BYTES + 1))
		else $error("byte count past saturation");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < BLK_POS_W'(DATA_BLOCK_BYTES))
		else $error("block position beyond data block");
`endif

endmodule

// ----- hw/rtl/wmbus_frame_a_checker.sv -----
// Top level of the wireless M-Bus format A frame checker: handshake, input and result registers.
//
//  channel  dir  handshake          word
//  -------  ---  -----------------  -------------------------------------
//  in       in   in_valid/in_stall  data_byte, frame_end
//  out      out  out_valid/out_stall frame_ok, frame_length, error_code
//
// One byte per cycle while no frame_end byte waits on a held result: each byte
// is registered in the input register, the unrolled 8-bit CRC update and block
// tracking run on the registered byte, and a verdict lands in the result register
// on the frame_end byte; out_valid is driven straight from the result register.
// arst_n clears the tracking state and both valid flags; no clearing pass.
// A stalled result only holds the input side when a new frame_end byte
// waits behind it; plain data bytes keep flowing.
module wmbus_frame_a_checker
	import wmfac_pkg::*;
#(
	parameter int MAX_RECEIVED_BYTES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   frame_end,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   frame_ok,
	output logic [FRAME_LEN_W-1:0] frame_length,
	output logic [2:0]             error_code
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;
	logic       go;
	verdict_t   verdict;

	logic                   out_valid_q;
	logic                   frame_ok_q;
	logic [FRAME_LEN_W-1:0] frame_length_q;
	err_code_t              error_code_q;

	// Advance the staged byte unless it closes a frame and the result slot is
	// still held by the downstream side.
	assign go       = valid_s1 && (!end_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload: load with each accepted word, hold while stalled.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	wmfac_track #(
		.MAX_RECEIVED_BYTES(MAX_RECEIVED_BYTES)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (go),
		.data_byte(data_s1),
		.frame_end(end_s1),
		.verdict  (verdict)
	);

	// Result register: fill on a frame_end byte, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && end_s1) begin
			frame_ok_q     <= verdict.ok;
			frame_length_q <= verdict.length;
			error_code_q   <= verdict.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_ok     = frame_ok_q;
	assign frame_length = frame_length_q;
	assign error_code   = error_code_q;

`ifndef ASSERT_OFF
	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> frame_ok_q == (error_code_q == ERR_NONE))
		else $error("frame_ok disagrees with error code");
	a_err_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !frame_ok_q |-> frame_length_q == '0)
		else $error("nonzero length on a failed frame");
	a_stall_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && end_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked frame end");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the wireless M-Bus format A frame checker.
module testbench
	import wmfac_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int RESET_CYCLES    = 9;
	localparam int HOLD_CYCLES     = 400;   // long receiver hold-off in the pressure phase
	localparam int TAIL_CYCLES     = 12;    // leave ample slack after the last verdict
	localparam int LIMIT_CYCLES    = 300000;
	localparam int IMG_BYTES       = 320;   // longest frame image: L = 255 spans 290 bytes
	localparam int PHASE_BYTES     = 180;
	localparam int MAX_RANDOM_LEN  = 80;

	// Fill pattern for the data bytes of a built frame.
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	// One frame to build: L field, bytes to send, fill, byte to corrupt (-1: none),
	// whether the last byte carries frame_end, and an optional hand-written verdict.
	typedef struct {
		int       l_field;
		int       n_bytes;
		fill_t    fill;
		int       bad_at;
		bit       has_end;
		bit       typed;
		verdict_t v;
	} frame_recipe_t;

	// One input word as queued for the sender.
	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         typed;
		verdict_t   v;
	} rx_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             data_byte = 8'h00;
	logic                   frame_end = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   frame_ok;
	logic [FRAME_LEN_W-1:0] frame_length;
	logic [2:0]             error_code;

	wmbus_frame_a_checker #(
		.MAX_RECEIVED_BYTES(MAX_FRAME_BYTES)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_ok    (frame_ok),
		.frame_length(frame_length),
		.error_code  (error_code)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Words waiting to be offered, verdicts waiting to come out.
	rx_word_t word_q[$];
	verdict_t verdict_q[$];
	rx_word_t cur_word;

	int mismatches    = 0;
	int cycle_count   = 0;
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int hold_requests = 0;

	// Frame tracking state of the predictor; all of it clears after each frame_end word.
	logic [15:0] crc_acc    = '0;
	logic [6:0]  bytes_seen = '0;
	logic [4:0]  blk_off    = '0;
	logic [8:0]  span_len   = '0;
	bit          hdr_fail   = 1'b0;
	bit          blk_fail   = 1'b0;
	bit          crc_hi_ok  = 1'b0;

	// Directed frames. A verdict is typed in only where it is obvious from the frame;
	// the remaining rows rely on the predictor.
	frame_recipe_t directed_rows[22] = '{
		// single byte straight after reset
		'{9,   1,  FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_SHORT}},
		// bare header, L = 9 with all-zero data and L = 6 with all-one data
		'{9,   12, FILL_ZERO,   -1, 1'b1, 1'b1, '{1'b1, 7'd12, ERR_NONE}},
		'{6,   12, FILL_ONES,   -1, 1'b1, 1'b1, '{1'b1, 7'd12, ERR_NONE}},
		// short length field: expects 11 bytes, header only is checked
		'{8,   12, FILL_RANDOM, -1, 1'b1, 1'b0, '{1'b0, 7'd0,  ERR_NONE}},
		// smallest data block, largest passing frame, trailing bytes left unchecked
		'{10,  15, FILL_ZERO,   -1, 1'b1, 1'b1, '{1'b1, 7'd15, ERR_NONE}},
		'{46,  55, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b1, 7'd55, ERR_NONE}},
		'{46,  64, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b1, 7'd55, ERR_NONE}},
		// one byte short of a header, far too many bytes
		'{25,  11, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_SHORT}},
		'{30,  70, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LONG}},
		// header CRC: data byte, high CRC byte, low CRC byte corrupted
		'{20,  12, FILL_RANDOM, 3,  1'b1, 1'b1, '{1'b0, 7'd0,  ERR_HDR_CRC}},
		'{20,  12, FILL_RANDOM, 10, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_HDR_CRC}},
		'{20,  12, FILL_RANDOM, 11, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_HDR_CRC}},
		// frame cut short of its L field
		'{20,  20, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LEN_OVER}},
		'{255, 64, FILL_ONES,   -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LEN_OVER}},
		// length below the minimum, above the maximum
		'{0,   12, FILL_ZERO,   -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LEN_MIN}},
		'{5,   12, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LEN_MIN}},
		'{47,  56, FILL_RANDOM, -1, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_LEN_MAX}},
		// data block CRC: inside the first block, last byte of the last block
		'{40,  47, FILL_RANDOM, 20, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_BLK_CRC}},
		'{40,  47, FILL_RANDOM, 46, 1'b1, 1'b1, '{1'b0, 7'd0,  ERR_BLK_CRC}},
		// bytes with no frame_end run on into the next frame
		'{12,  5,  FILL_RANDOM, -1, 1'b0, 1'b0, '{1'b0, 7'd0,  ERR_NONE}},
		'{9,   12, FILL_RANDOM, -1, 1'b1, 1'b0, '{1'b0, 7'd0,  ERR_NONE}},
		// two data blocks
		'{26,  33, FILL_RANDOM, -1, 1'b1, 1'b0, '{1'b0, 7'd0,  ERR_NONE}}
	};

	int tx_idle_tab[4] = '{0, 63, 0, 19};
	int rx_stall_tab[4] = '{0, 0, 63, 19};

	// Advance a CRC-16 (poly 0x3D65) by one byte, MSB first.
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h3D65) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// Frame span in bytes implied by the L field, CRC bytes included.
	function automatic logic [8:0] frame_span(input logic [7:0] l);
		int n;
		n = l + 3;
		if (l > LEN_MIN) begin
			n += 2 * ((l - LEN_MIN + 15) / 16);
		end
		return 9'(n);
	endfunction

	function automatic logic [7:0] fill_byte(input fill_t f);
		case (f)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'($urandom_range(255));
		endcase
	endfunction

	// Predict the checker: absorb one accepted word; on frame_end, hand back the verdict
	// and clear the tracking state.
	function automatic bit absorb_byte(input logic [7:0] b, input logic last,
			output verdict_t v);
		int          idx;
		int          first;
		int          part;
		logic [15:0] chk;
		err_code_t   err;
		idx = bytes_seen;
		chk = ~crc_acc;
		v   = '0;
		if (idx < MAX_FRAME_BYTES) begin
			if (idx == 0) begin
				span_len = frame_span(b);
			end
			if (idx < HEADER_BLOCK_BYTES - 2) begin
				crc_acc = crc16_step(crc_acc, b);
			end else if (idx == HEADER_BLOCK_BYTES - 2) begin
				crc_hi_ok = (chk[15:8] == b);
			end else if (idx == HEADER_BLOCK_BYTES - 1) begin
				hdr_fail = !(crc_hi_ok && chk[7:0] == b);
				crc_acc  = '0;
				blk_off  = '0;
			end else if (idx < int'(span_len)) begin
				// block length: a full block or whatever is left of the frame
				first = idx - int'(blk_off);
				part  = int'(span_len) - first;
				if (part > DATA_BLOCK_BYTES) begin
					part = DATA_BLOCK_BYTES;
				end
				if (int'(blk_off) + 2 < part) begin
					crc_acc = crc16_step(crc_acc, b);
					blk_off = blk_off + 5'd1;
				end else if (int'(blk_off) + 2 == part) begin
					crc_hi_ok = (chk[15:8] == b);
					blk_off   = blk_off + 5'd1;
				end else begin
					if (!(crc_hi_ok && chk[7:0] == b)) begin
						blk_fail = 1'b1;
					end
					crc_acc = '0;
					blk_off = '0;
				end
			end
		end
		if (bytes_seen < 7'(MAX_FRAME_BYTES + 1)) begin
			bytes_seen = bytes_seen + 7'd1;
		end
		if (!last) begin
			return 1'b0;
		end

		// first failing check wins
		if (bytes_seen < HEADER_BLOCK_BYTES) begin
			err = ERR_SHORT;
		end else if (bytes_seen > MAX_FRAME_BYTES) begin
			err = ERR_LONG;
		end else if (hdr_fail) begin
			err = ERR_HDR_CRC;
		end else if (span_len > bytes_seen) begin
			err = ERR_LEN_OVER;
		end else if (span_len < LEN_MIN) begin
			err = ERR_LEN_MIN;
		end else if (span_len > LEN_MAX) begin
			err = ERR_LEN_MAX;
		end else if (blk_fail) begin
			err = ERR_BLK_CRC;
		end else begin
			err = ERR_NONE;
		end
		v.ok  = (err == ERR_NONE);
		v.err = err;
		if (err == ERR_NONE) begin
			v.length = (span_len < HEADER_BLOCK_BYTES) ? 7'(HEADER_BLOCK_BYTES) : span_len[6:0];
		end

		crc_acc    = '0;
		bytes_seen = '0;
		blk_off    = '0;
		span_len   = '0;
		hdr_fail   = 1'b0;
		blk_fail   = 1'b0;
		crc_hi_ok  = 1'b0;
		return 1'b1;
	endfunction

	// Build a frame image with correct block CRCs for its L field, corrupt one byte if
	// asked, and queue the first n_bytes of it.
	task automatic queue_frame(input frame_recipe_t r);
		logic [7:0]  img [IMG_BYTES];
		logic [15:0] crc;
		int          span;
		int          blk_start;
		int          blk_len;
		span = frame_span(8'(r.l_field));
		for (int k = 0; k < IMG_BYTES; k++) begin
			img[k] = fill_byte(r.fill);
		end
		img[0]    = 8'(r.l_field);
		blk_start = 0;
		blk_len   = HEADER_BLOCK_BYTES;
		while (blk_start + blk_len <= IMG_BYTES && (blk_start == 0 || blk_start < span)) begin
			crc = '0;
			for (int k = blk_start; k < blk_start + blk_len - 2; k++) begin
				crc = crc16_step(crc, img[k]);
			end
			crc = ~crc;
			img[blk_start + blk_len - 2] = crc[15:8];
			img[blk_start + blk_len - 1] = crc[7:0];
			blk_start += blk_len;
			blk_len = (span - blk_start > DATA_BLOCK_BYTES) ? DATA_BLOCK_BYTES : span - blk_start;
		end
		if (r.bad_at >= 0 && r.bad_at < r.n_bytes) begin
			img[r.bad_at] ^= 8'($urandom_range(1, 255));
		end
		for (int k = 0; k < r.n_bytes; k++) begin
			word_q.push_back('{img[k], r.has_end && (k == r.n_bytes - 1), r.typed, r.v});
		end
	endtask

	// Mostly well-formed frames with random content; some truncated, overlong, padded,
	// corrupted or left without frame_end.
	task automatic queue_random_frames(input int budget);
		frame_recipe_t r;
		int            goal;
		goal = word_q.size() + budget;
		while (word_q.size() < goal) begin
			r.l_field = ($urandom_range(99) < 70) ? $urandom_range(6, 46) : $urandom_range(0, 255);
			r.n_bytes = frame_span(8'(r.l_field));
			if (r.n_bytes < HEADER_BLOCK_BYTES) begin
				r.n_bytes = HEADER_BLOCK_BYTES;
			end
			if (r.n_bytes > MAX_RANDOM_LEN) begin
				r.n_bytes = $urandom_range(HEADER_BLOCK_BYTES, MAX_RANDOM_LEN);
			end
			case ($urandom_range(19))
				0, 1:    r.n_bytes = $urandom_range(1, r.n_bytes);
				2:       r.n_bytes += $urandom_range(1, 12);
				3:       r.n_bytes = $urandom_range(MAX_FRAME_BYTES + 1, MAX_RANDOM_LEN);
				default: ;
			endcase
			case ($urandom_range(15))
				0:       r.fill = FILL_ZERO;
				1:       r.fill = FILL_ONES;
				default: r.fill = FILL_RANDOM;
			endcase
			r.bad_at  = ($urandom_range(6) == 0) ? $urandom_range(0, r.n_bytes - 1) : -1;
			r.has_end = ($urandom_range(24) != 0);
			r.typed   = 1'b0;
			r.v       = '0;
			queue_frame(r);
		end
	endtask

	// Offer queued words until all are accepted. Hold a stalled word unchanged; otherwise
	// go idle at the current rate or present the next word.
	task automatic send_all();
		verdict_t got;
		while (word_q.size() > 0 || in_valid) begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				if (absorb_byte(cur_word.b, cur_word.last, got)) begin
					verdict_q.push_back(cur_word.typed ? cur_word.v : got);
				end
			end
			if (in_valid && in_stall) begin
				// hold the word in place
			end else if (word_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				cur_word = word_q.pop_front();
				in_valid  <= 1'b1;
				data_byte <= cur_word.b;
				frame_end <= cur_word.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	endtask

	// Pause the sender until every verdict still owed has come out.
	task automatic drain();
		while (verdict_q.size() > 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: random stall at the current rate, or a long hold-off when requested.
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served    = 0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served    = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// Compare each accepted verdict word against the oldest one owed.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict ok=%0b length=%0d error=%0d",
					$time, frame_ok, frame_length, error_code);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (frame_ok !== want.ok) begin
					$display("%0t: frame_ok expected %0b got %0b", $time, want.ok, frame_ok);
					mismatches++;
				end
				if (frame_length !== want.length) begin
					$display("%0t: frame_length expected %0d got %0d",
						$time, want.length, frame_length);
					mismatches++;
				end
				if (error_code !== want.err) begin
					$display("%0t: error_code expected %0d got %0d",
						$time, want.err, error_code);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames, no idling on either side.
		foreach (directed_rows[i]) begin
			queue_frame(directed_rows[i]);
		end
		send_all();
		drain();

		// Random frames under each idling mix; the sender waits for the block to empty
		// between phases.
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_idle_tab[ph];
			rx_stall_pct = rx_stall_tab[ph];
			queue_random_frames(PHASE_BYTES);
			send_all();
			drain();
		end

		// Pressure: hold the receiver off while the sender streams one-byte frames, so
		// the result register fills and the input side stalls.
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_requests++;
		for (int k = 0; k < 40; k++) begin
			word_q.push_back('{8'($urandom_range(255)), 1'b1, 1'b0, verdict_t'('0)});
		end
		queue_random_frames(120);
		send_all();
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
